>>> hw/rtl/idll_pkg.sv
// Shared types for the indexed doubly linked list: action and status codes
// and the control word that the sequencer sends to the node store.
// No dependencies.
package idll_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INS_AFTER  = 3'd4,
    ACT_INS_BEFORE = 3'd5,
    ACT_REMOVE     = 3'd6,
    ACT_READ       = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_ELEMENTS = 2'd1,
    ST_FULL        = 2'd2,
    ST_BAD_INDEX   = 2'd3
  } status_t;

  // Strobes into the node store: one read of all three arrays, or writes.
  typedef struct packed {
    logic rd;
    logic lk_we;
    logic pv_we;
    logic el_we;
  } mem_ctl_t;

endpackage

>>> hw/rtl/idll_store.sv
// Node store of the linked list: next link with live mark, prev link and
// element arrays, each a synchronous memory with a registered read port.
// Depends on idll_pkg.
module idll_store #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  idll_pkg::mem_ctl_t                  ctl,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   rd_addr,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   lk_addr,
  input  logic                                lk_live,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   lk_next,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   pv_addr,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   pv_data,
  input  logic [DATA_WIDTH - 1:0]             el_data,
  output logic                                rd_live,
  output logic [$clog2(CAPACITY + 1) - 1:0]   rd_next,
  output logic [$clog2(CAPACITY + 1) - 1:0]   rd_prev,
  output logic [DATA_WIDTH - 1:0]             rd_data
);
  import idll_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W - 1:0] CAP_IDX = IDX_W'(CAPACITY);

  logic [IDX_W:0]          lk_mem [0:CAPACITY];
  logic [IDX_W - 1:0]      pv_mem [0:CAPACITY];
  logic [DATA_WIDTH - 1:0] el_mem [0:CAPACITY];

  logic [IDX_W:0]          lk_q;
  logic [IDX_W - 1:0]      pv_q;
  logic [DATA_WIDTH - 1:0] el_q;
  logic [IDX_W - 1:0]      raddr_r;
  logic [IDX_W - 1:0]      hw_r;
  logic                    fresh;

  always_ff @(posedge clk) begin
    if (ctl.lk_we) begin
      lk_mem[lk_addr] <= {lk_live, lk_next};
    end
    if (ctl.pv_we) begin
      pv_mem[pv_addr] <= pv_data;
    end
    if (ctl.el_we) begin
      el_mem[lk_addr] <= el_data;
    end
    if (ctl.rd) begin
      lk_q    <= lk_mem[rd_addr];
      pv_q    <= pv_mem[rd_addr];
      el_q    <= el_mem[rd_addr];
      raddr_r <= rd_addr;
    end
  end

  // Nodes are first taken from the free stack in ascending order, so every
  // node above the highest one ever written still holds its reset link.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
    end else if (ctl.lk_we && (lk_addr > hw_r)) begin
      hw_r <= lk_addr;
    end
  end

  assign fresh   = raddr_r > hw_r;
  assign rd_live = fresh ? 1'b0 : lk_q[IDX_W];
  assign rd_next = fresh ? ((raddr_r == CAP_IDX) ? '0 : raddr_r + IDX_W'(1))
                         : lk_q[IDX_W - 1:0];
  assign rd_prev = pv_q;
  assign rd_data = el_q;

endmodule

>>> hw/rtl/idll_ctrl.sv
// Sequencer of the linked list: takes one action word, reads the node store,
// then writes the new links back in the LINK1 and LINK2 or UNL1 and UNL2 states. Holds
// the sentinel links, the free stack top and the element count. Depends on idll_pkg.
module idll_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_action,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   in_node_index,
  input  logic [DATA_WIDTH - 1:0]             in_data_in,
  output logic                                res_valid,
  input  logic                                res_ready,
  output idll_pkg::status_t                   res_status,
  output logic [DATA_WIDTH - 1:0]             res_data,
  output logic [$clog2(CAPACITY + 1) - 1:0]   res_node,
  output logic [$clog2(CAPACITY + 1) - 1:0]   res_next,
  output logic [$clog2(CAPACITY + 1) - 1:0]   res_prev,
  output logic [$clog2(CAPACITY + 1) - 1:0]   res_length,
  output idll_pkg::mem_ctl_t                  mem_ctl,
  output logic [$clog2(CAPACITY + 1) - 1:0]   rd_addr,
  output logic [$clog2(CAPACITY + 1) - 1:0]   lk_addr,
  output logic                                lk_live,
  output logic [$clog2(CAPACITY + 1) - 1:0]   lk_next,
  output logic [$clog2(CAPACITY + 1) - 1:0]   pv_addr,
  output logic [$clog2(CAPACITY + 1) - 1:0]   pv_data,
  output logic [DATA_WIDTH - 1:0]             el_data,
  input  logic                                rd_live,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   rd_next,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   rd_prev,
  input  logic [DATA_WIDTH - 1:0]             rd_data
);
  import idll_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W - 1:0] CAP_IDX = IDX_W'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_LINK1 = 7'b0000100,
    S_LINK2 = 7'b0001000,
    S_UNL1  = 7'b0010000,
    S_UNL2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } fsm_state_t;

  fsm_state_t              state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic [IDX_W - 1:0]      idx_r, idx_nxt;
  logic [DATA_WIDTH - 1:0] din_r, din_nxt;
  logic [IDX_W - 1:0]      head_r, head_nxt;
  logic [IDX_W - 1:0]      tail_r, tail_nxt;
  logic [IDX_W - 1:0]      free_r, free_nxt;
  logic [IDX_W - 1:0]      cnt_r, cnt_nxt;
  logic [IDX_W - 1:0]      node_r, node_nxt;
  logic [IDX_W - 1:0]      aft_r, aft_nxt;
  logic [IDX_W - 1:0]      fol_r, fol_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [DATA_WIDTH - 1:0] res_data_r, res_data_nxt;
  logic [IDX_W - 1:0]      res_node_r, res_node_nxt;
  logic [IDX_W - 1:0]      res_next_r, res_next_nxt;
  logic [IDX_W - 1:0]      res_prev_r, res_prev_nxt;

  logic                    idx_live;
  logic [IDX_W - 1:0]      nx_i;
  logic [IDX_W - 1:0]      pv_i;
  logic [IDX_W - 1:0]      tgt;
  logic                    unlink;

  // The sentinel lives in registers; it always counts as live.
  assign idx_live = (idx_r == '0) || ((idx_r <= CAP_IDX) && rd_live);
  assign nx_i     = (idx_r == '0) ? head_r : rd_next;
  assign pv_i     = (idx_r == '0) ? tail_r : rd_prev;
  assign tgt      = (act_r == ACT_POP_BACK)  ? tail_r :
                    (act_r == ACT_POP_FRONT) ? head_r : idx_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    din_nxt        = din_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    cnt_nxt        = cnt_r;
    node_nxt       = node_r;
    aft_nxt        = aft_r;
    fol_nxt        = fol_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_node_nxt   = res_node_r;
    res_next_nxt   = res_next_r;
    res_prev_nxt   = res_prev_r;
    mem_ctl        = '0;
    rd_addr        = in_node_index;
    lk_addr        = node_r;
    lk_live        = 1'b1;
    lk_next        = fol_r;
    pv_addr        = node_r;
    pv_data        = aft_r;
    res_valid      = 1'b0;
    unlink         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = action_t'(in_action);
          idx_nxt   = in_node_index;
          din_nxt   = in_data_in;
          state_nxt = S_EVAL;
          case (action_t'(in_action))
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
              rd_addr    = free_r;
              mem_ctl.rd = free_r != '0;
            end
            ACT_POP_BACK: begin
              rd_addr    = tail_r;
              mem_ctl.rd = tail_r != '0;
            end
            ACT_POP_FRONT: begin
              rd_addr    = head_r;
              mem_ctl.rd = head_r != '0;
            end
            default: begin
              rd_addr    = in_node_index;
              mem_ctl.rd = (in_node_index != '0) && (in_node_index <= CAP_IDX);
            end
          endcase
        end
      end

      S_EVAL: begin
        res_status_nxt = ST_OK;
        res_data_nxt   = '0;
        res_node_nxt   = '0;
        res_next_nxt   = '0;
        res_prev_nxt   = '0;
        state_nxt      = S_DONE;
        case (act_r)
          ACT_READ: begin
            if (!idx_live) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              res_node_nxt = idx_r;
              res_data_nxt = (idx_r == '0) ? '0 : rd_data;
              res_next_nxt = nx_i;
              res_prev_nxt = pv_i;
            end
          end
          ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (free_r == '0) begin
              res_status_nxt = ST_FULL;
            end else begin
              node_nxt  = free_r;
              aft_nxt   = (act_r == ACT_PUSH_BACK) ? tail_r : '0;
              fol_nxt   = (act_r == ACT_PUSH_BACK) ? '0 : head_r;
              state_nxt = S_LINK1;
            end
          end
          ACT_INS_AFTER, ACT_INS_BEFORE: begin
            if (!idx_live) begin
              res_status_nxt = ST_BAD_INDEX;
            end else if (free_r == '0) begin
              res_status_nxt = ST_FULL;
            end else begin
              node_nxt   = free_r;
              aft_nxt    = (act_r == ACT_INS_AFTER) ? idx_r : pv_i;
              fol_nxt    = (act_r == ACT_INS_AFTER) ? nx_i : idx_r;
              // The free node's link is needed to pop the free stack.
              rd_addr    = free_r;
              mem_ctl.rd = 1'b1;
              state_nxt  = S_LINK1;
            end
          end
          ACT_POP_BACK, ACT_POP_FRONT: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_NO_ELEMENTS;
            end else begin
              unlink = 1'b1;
            end
          end
          default: begin
            if (idx_r == '0) begin
              res_status_nxt = ST_NO_ELEMENTS;
            end else if (!idx_live) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              unlink = 1'b1;
            end
          end
        endcase
        if (unlink) begin
          node_nxt     = tgt;
          aft_nxt      = rd_prev;
          fol_nxt      = rd_next;
          res_node_nxt = tgt;
          res_data_nxt = rd_data;
          res_next_nxt = rd_next;
          res_prev_nxt = rd_prev;
          state_nxt    = S_UNL1;
        end
      end

      S_LINK1: begin
        mem_ctl.lk_we = 1'b1;
        mem_ctl.pv_we = 1'b1;
        mem_ctl.el_we = 1'b1;
        lk_addr       = node_r;
        lk_live       = 1'b1;
        lk_next       = fol_r;
        pv_addr       = node_r;
        pv_data       = aft_r;
        free_nxt      = rd_next;
        cnt_nxt       = cnt_r + IDX_W'(1);
        res_node_nxt  = node_r;
        res_next_nxt  = fol_r;
        res_prev_nxt  = aft_r;
        state_nxt     = S_LINK2;
      end

      S_LINK2: begin
        if (aft_r == '0) begin
          head_nxt = node_r;
        end else begin
          mem_ctl.lk_we = 1'b1;
          lk_addr       = aft_r;
          lk_live       = 1'b1;
          lk_next       = node_r;
        end
        if (fol_r == '0) begin
          tail_nxt = node_r;
        end else begin
          mem_ctl.pv_we = 1'b1;
          pv_addr       = fol_r;
          pv_data       = node_r;
        end
        state_nxt = S_DONE;
      end

      S_UNL1: begin
        // The removed node goes on top of the free stack.
        mem_ctl.lk_we = 1'b1;
        lk_addr       = node_r;
        lk_live       = 1'b0;
        lk_next       = free_r;
        free_nxt      = node_r;
        cnt_nxt       = cnt_r - IDX_W'(1);
        if (fol_r == '0) begin
          tail_nxt = aft_r;
        end else begin
          mem_ctl.pv_we = 1'b1;
          pv_addr       = fol_r;
          pv_data       = aft_r;
        end
        state_nxt = S_UNL2;
      end

      S_UNL2: begin
        if (aft_r == '0) begin
          head_nxt = fol_r;
        end else begin
          mem_ctl.lk_we = 1'b1;
          lk_addr       = aft_r;
          lk_live       = 1'b1;
          lk_next       = fol_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= IDX_W'(1);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    idx_r        <= idx_nxt;
    din_r        <= din_nxt;
    node_r       <= node_nxt;
    aft_r        <= aft_nxt;
    fol_r        <= fol_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_node_r   <= res_node_nxt;
    res_next_r   <= res_next_nxt;
    res_prev_r   <= res_prev_nxt;
  end

  assign in_ready   = state_r == S_IDLE;
  assign el_data    = din_r;
  assign res_status = res_status_r;
  assign res_data   = res_data_r;
  assign res_node   = res_node_r;
  assign res_next   = res_next_r;
  assign res_prev   = res_prev_r;
  assign res_length = cnt_r;

endmodule

>>> hw/rtl/indexed_doubly_linked_list.sv
// Indexed doubly linked list with a free stack; top level with the output word register.
// On acceptance the node store is read and the word evaluated; a read or a rejected action
// then goes to the done state, while an insert, push, pop or remove first passes the LINK1
// and LINK2 or UNL1 and UNL2 write states. The next word is taken only once the result has
// gone to the output register and the sequencer is back in idle. Reset is synchronous; no
// clearing pass is needed. Depends on idll_pkg, idll_store and idll_ctrl.
module indexed_doubly_linked_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_action,
  input  logic [$clog2(CAPACITY + 1) - 1:0]   in_node_index,
  input  logic [DATA_WIDTH - 1:0]             in_data_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [DATA_WIDTH - 1:0]             out_data_out,
  output logic [$clog2(CAPACITY + 1) - 1:0]   out_node_out,
  output logic [$clog2(CAPACITY + 1) - 1:0]   out_next_out,
  output logic [$clog2(CAPACITY + 1) - 1:0]   out_prev_out,
  output logic [$clog2(CAPACITY + 1) - 1:0]   out_live_length
);
  import idll_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);

  mem_ctl_t                mem_ctl;
  logic [IDX_W - 1:0]      rd_addr, lk_addr, lk_next, pv_addr, pv_data;
  logic                    lk_live, rd_live;
  logic [IDX_W - 1:0]      rd_next, rd_prev;
  logic [DATA_WIDTH - 1:0] el_data, rd_data;

  logic                    res_valid, res_ready;
  status_t                 res_status;
  logic [DATA_WIDTH - 1:0] res_data;
  logic [IDX_W - 1:0]      res_node, res_next, res_prev, res_length;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r;
  logic [DATA_WIDTH - 1:0] data_r;
  logic [IDX_W - 1:0]      node_r, next_r, prev_r, length_r;
  logic                    load;

  idll_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_node_index (in_node_index),
    .in_data_in    (in_data_in),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_status    (res_status),
    .res_data      (res_data),
    .res_node      (res_node),
    .res_next      (res_next),
    .res_prev      (res_prev),
    .res_length    (res_length),
    .mem_ctl       (mem_ctl),
    .rd_addr       (rd_addr),
    .lk_addr       (lk_addr),
    .lk_live       (lk_live),
    .lk_next       (lk_next),
    .pv_addr       (pv_addr),
    .pv_data       (pv_data),
    .el_data       (el_data),
    .rd_live       (rd_live),
    .rd_next       (rd_next),
    .rd_prev       (rd_prev),
    .rd_data       (rd_data)
  );

  idll_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .lk_addr (lk_addr),
    .lk_live (lk_live),
    .lk_next (lk_next),
    .pv_addr (pv_addr),
    .pv_data (pv_data),
    .el_data (el_data),
    .rd_live (rd_live),
    .rd_next (rd_next),
    .rd_prev (rd_prev),
    .rd_data (rd_data)
  );

  // The output word register frees the sequencer while a word waits.
  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res_status;
      data_r   <= res_data;
      node_r   <= res_node;
      next_r   <= res_next;
      prev_r   <= res_prev;
      length_r <= res_length;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_node_out    = node_r;
  assign out_next_out    = next_r;
  assign out_prev_out    = prev_r;
  assign out_live_length = length_r;

endmodule

>>> tb/sv/idll_tb_pkg.sv
// Scoreboard for the indexed doubly linked list bench: a mirror of the node
// store that forecasts each reply word, and the checks against what comes out.
// Depends on idll_pkg.
`timescale 1ns / 100ps
package idll_tb_pkg;
  import idll_pkg::*;

  localparam int CAP    = 64;
  localparam int IDX_W  = 7;
  localparam int DATA_W = 32;

  typedef struct {
    status_t             status;
    logic [DATA_W - 1:0] data;
    logic [IDX_W - 1:0]  node;
    logic [IDX_W - 1:0]  nxt;
    logic [IDX_W - 1:0]  prv;
    logic [IDX_W - 1:0]  len;
  } reply_t;

  class list_scoreboard;
    logic [IDX_W - 1:0]  next_link [0:CAP];
    logic [IDX_W - 1:0]  prev_link [0:CAP];
    logic [DATA_W - 1:0] elems     [0:CAP];
    bit                  live      [0:CAP];
    logic [IDX_W - 1:0]  free_top;
    logic [IDX_W - 1:0]  count;

    reply_t forecast_q[$];
    int     errors;
    int     replies_checked;
    int     status_hits [4];
    int     peak_len;
    int     times_filled;
    int     times_emptied;

    function new();
      for (int i = 0; i <= CAP; i++) begin
        next_link[i] = (i == 0 || i == CAP) ? '0 : IDX_W'(i + 1);
        prev_link[i] = '0;
        elems[i]     = '0;
        live[i]      = (i == 0);
      end
      free_top = 1;
      count    = 0;
      errors   = 0;
      replies_checked = 0;
      peak_len = 0;
      times_filled  = 0;
      times_emptied = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function bit is_live(logic [IDX_W - 1:0] idx);
      return idx <= CAP && live[idx];
    endfunction

    function int outstanding();
      return forecast_q.size();
    endfunction

    // Applies one accepted word to the mirror and queues the reply it must give.
    function void note_request(action_t act, logic [IDX_W - 1:0] idx,
                               logic [DATA_W - 1:0] value);
      reply_t r;
      logic [IDX_W - 1:0] after, follow, n, target, p, f;
      r = '{status: ST_OK, data: '0, node: '0, nxt: '0, prv: '0, len: '0};
      after  = '0;
      target = '0;
      case (act)
        ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INS_AFTER, ACT_INS_BEFORE: begin
          if (act == ACT_PUSH_BACK) after = prev_link[0];
          else if (act == ACT_PUSH_FRONT) after = '0;
          else if (!is_live(idx)) r.status = ST_BAD_INDEX;
          else if (act == ACT_INS_AFTER) after = idx;
          else after = prev_link[idx];
          if (r.status == ST_OK && free_top == 0) r.status = ST_FULL;
          if (r.status == ST_OK) begin
            n            = free_top;
            follow       = next_link[after];
            free_top     = next_link[n];
            elems[n]     = value;
            next_link[n] = follow;
            prev_link[n] = after;
            prev_link[follow] = n;
            next_link[after]  = n;
            live[n]      = 1'b1;
            count++;
            r.node = n;
            r.nxt  = follow;
            r.prv  = after;
            if (count > peak_len) peak_len = count;
            if (count == CAP) times_filled++;
          end
        end
        ACT_READ: begin
          if (!is_live(idx)) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.node = idx;
            r.data = (idx == 0) ? '0 : elems[idx];
            r.nxt  = next_link[idx];
            r.prv  = prev_link[idx];
          end
        end
        default: begin
          if (act == ACT_POP_BACK || act == ACT_POP_FRONT) begin
            if (count == 0) r.status = ST_NO_ELEMENTS;
            else target = (act == ACT_POP_BACK) ? prev_link[0] : next_link[0];
          end else if (idx == 0) begin
            r.status = ST_NO_ELEMENTS;
          end else if (!is_live(idx)) begin
            r.status = ST_BAD_INDEX;
          end else begin
            target = idx;
          end
          if (r.status == ST_OK && target == 0) r.status = ST_NO_ELEMENTS;
          if (r.status == ST_OK) begin
            p = prev_link[target];
            f = next_link[target];
            r.node = target;
            r.data = elems[target];
            r.nxt  = f;
            r.prv  = p;
            next_link[p] = f;
            prev_link[f] = p;
            next_link[target] = free_top;
            free_top     = target;
            live[target] = 1'b0;
            count--;
            if (count == 0) times_emptied++;
          end
        end
      endcase
      r.len = count;
      status_hits[r.status]++;
      forecast_q.push_back(r);
    endfunction

    task report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("[%0t] reply %0d: %s is %0h, expected %0h", $time, replies_checked,
               field, got, want);
      errors++;
    endtask

    task check_response(logic [1:0] st, logic [DATA_W - 1:0] d, logic [IDX_W - 1:0] node,
                        logic [IDX_W - 1:0] nxt, logic [IDX_W - 1:0] prv,
                        logic [IDX_W - 1:0] len);
      reply_t w;
      if (forecast_q.size() == 0) begin
        report_mismatch("word with nothing outstanding, status", st, 0);
        return;
      end
      w = forecast_q.pop_front();
      if (st !== w.status) report_mismatch("status", st, w.status);
      if (d !== w.data) report_mismatch("data_out", d, w.data);
      if (node !== w.node) report_mismatch("node_out", node, w.node);
      if (nxt !== w.nxt) report_mismatch("next_out", nxt, w.nxt);
      if (prv !== w.prv) report_mismatch("prev_out", prv, w.prv);
      if (len !== w.len) report_mismatch("live_length", len, w.len);
      replies_checked++;
    endtask
  endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level bench for indexed_doubly_linked_list: directed edge cases, then
// random fill and drain traffic under several idling patterns on both channels.
// Depends on idll_pkg, idll_tb_pkg and the block's RTL.
`timescale 1ns / 100ps
module testbench;
  import idll_pkg::*;
  import idll_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 425;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_action = '0;
  logic [IDX_W - 1:0]  in_node_index = '0;
  logic [DATA_W - 1:0] in_data_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [DATA_W - 1:0] out_data_out;
  logic [IDX_W - 1:0]  out_node_out;
  logic [IDX_W - 1:0]  out_next_out;
  logic [IDX_W - 1:0]  out_prev_out;
  logic [IDX_W - 1:0]  out_live_length;

  list_scoreboard sb;
  int  idle_pct  = 0;
  int  stall_pct = 0;
  int  words_sent = 0;
  bit  draining = 1'b0;

  indexed_doubly_linked_list #(.CAPACITY(CAP), .DATA_WIDTH(DATA_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_node_index(in_node_index), .in_data_in(in_data_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_data_out(out_data_out), .out_node_out(out_node_out),
    .out_next_out(out_next_out), .out_prev_out(out_prev_out),
    .out_live_length(out_live_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_valid && out_ready)
      sb.check_response(out_status, out_data_out, out_node_out, out_next_out,
                        out_prev_out, out_live_length);
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Valid is only lowered when a gap is wanted, so back-to-back words never
  // see two assignments to it in one step.
  task automatic send_word(action_t act, logic [IDX_W - 1:0] idx, logic [DATA_W - 1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_node_index <= idx;
    in_data_in    <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, idx, value);
    words_sent++;
  endtask

  function automatic logic [IDX_W - 1:0] pick_node();
    int r;
    logic [IDX_W - 1:0] cands[$];
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 70) begin
      for (int i = 1; i <= CAP; i++)
        if (sb.live[i]) cands.push_back(IDX_W'(i));
      if (cands.size() == 0) return '0;
      return cands[$urandom_range(cands.size() - 1)];
    end
    if (r < 85) return IDX_W'($urandom_range(CAP, 1));
    return IDX_W'($urandom_range(2 ** IDX_W - 1, CAP + 1));
  endfunction

  function automatic logic [DATA_W - 1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DATA_W'($urandom);
  endfunction

  // Mostly grows the list until it is full, then mostly shrinks it until empty,
  // so that both the full and the empty cases keep coming round.
  task automatic random_word();
    int r, k;
    action_t act;
    if (!draining && sb.count == CAP && $urandom_range(3) == 0) draining = 1'b1;
    if (draining && sb.count == 0 && $urandom_range(3) == 0) draining = 1'b0;
    r = $urandom_range(99);
    k = $urandom_range(3);
    if (r < 55 && !draining || r >= 75 && r < 90 && draining)
      act = action_t'(3'(k < 2 ? k : k + 2));
    else if (r < 55 || r >= 75 && r < 90)
      act = action_t'(3'(k == 0 ? ACT_REMOVE : ACT_POP_BACK + k % 2));
    else if (r < 75)
      act = ACT_READ;
    else
      act = action_t'(3'($urandom_range(7)));
    send_word(act, pick_node(), pick_value());
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 50, 0, 15};
    stall_by_phase = '{0, 0, 50, 15};
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, sentinel walk, inserts on both sides, bad nodes.
    send_word(ACT_POP_BACK, 7'd0, 32'h1234_5678);
    send_word(ACT_POP_FRONT, 7'd0, 32'h0);
    send_word(ACT_REMOVE, 7'd0, 32'h0);
    send_word(ACT_READ, 7'd0, 32'h0);
    send_word(ACT_READ, 7'd1, 32'h0);
    send_word(ACT_PUSH_BACK, 7'd0, 32'h0000_0000);
    send_word(ACT_PUSH_FRONT, 7'd127, 32'hFFFF_FFFF);
    send_word(ACT_INS_AFTER, 7'd1, 32'hA5A5_A5A5);
    send_word(ACT_INS_BEFORE, 7'd1, 32'h5A5A_5A5A);
    send_word(ACT_INS_AFTER, 7'd0, 32'h8000_0000);
    send_word(ACT_INS_BEFORE, 7'd0, 32'h0000_0001);
    send_word(ACT_READ, 7'd0, 32'h0);
    send_word(ACT_READ, 7'd3, 32'h0);
    send_word(ACT_READ, 7'd127, 32'h0);
    send_word(ACT_READ, 7'd65, 32'h0);
    send_word(ACT_INS_AFTER, 7'd64, 32'hDEAD_0001);
    send_word(ACT_REMOVE, 7'd100, 32'h0);
    send_word(ACT_REMOVE, 7'd4, 32'h0);
    send_word(ACT_REMOVE, 7'd4, 32'h0);
    send_word(ACT_INS_BEFORE, 7'd127, 32'hDEAD_0002);
    send_word(ACT_POP_BACK, 7'd0, 32'h0);
    send_word(ACT_POP_FRONT, 7'd0, 32'h0);
    send_word(ACT_POP_BACK, 7'd0, 32'h0);
    send_word(ACT_POP_FRONT, 7'd0, 32'h0);
    send_word(ACT_POP_BACK, 7'd64, 32'h0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (PHASE_WORDS) random_word();
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d words, checked %0d replies: %0d ok, %0d no_elements, %0d full, %0d bad_index.",
             words_sent, sb.replies_checked, sb.status_hits[ST_OK],
             sb.status_hits[ST_NO_ELEMENTS], sb.status_hits[ST_FULL],
             sb.status_hits[ST_BAD_INDEX]);
    $display("List peaked at %0d of %0d nodes; filled %0d times, emptied %0d times; %0d mismatches.",
             sb.peak_len, CAP, sb.times_filled, sb.times_emptied, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
